@@ hdl/circle_velocity_obstacle_macros.svh @@
// assertion macros used by the checker file
`ifndef CIRCLE_VELOCITY_OBSTACLE_MACROS_SVH
`define CIRCLE_VELOCITY_OBSTACLE_MACROS_SVH

// same-cycle implication
`define CVO_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CVO_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/cvo_pkg.sv @@
// shared types and constants of the circle velocity obstacle pipeline
`default_nettype none

package cvo_pkg;

   localparam int ANG_W      = 32;
   localparam int VEC_W      = 44;
   localparam int ROT_W      = 34;
   localparam int SQRT_STEPS = 21;
   localparam int ATAN_LEN   = 24;

   localparam logic [31:0] OVERLAP_OPENING = 32'd1073673467;
   localparam logic [33:0] CORDIC_GAIN_Q30 = 34'd652032874;

   localparam logic [31:0] ATAN_TABLE [ATAN_LEN] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   typedef struct packed {
      logic [40:0] n;
      logic [16:0] sum;
      logic        overlap;
      logic        zero;
      logic        neg;
      logic [19:0] vel_x;
      logic [19:0] vel_y;
   } brg_sb_type;

   typedef struct packed {
      logic [31:0] bearing;
      logic [16:0] sum;
      logic        overlap;
      logic [19:0] vel_x;
      logic [19:0] vel_y;
   } sq_sb_type;

   typedef struct packed {
      logic [31:0] bearing;
      logic        overlap;
      logic [19:0] vel_x;
      logic [19:0] vel_y;
   } opn_sb_type;

endpackage

`default_nettype wire

@@ hdl/cvo_vec.sv @@
// pipelined vectoring cordic: angle of (x, y) for x >= 0, one micro-rotation per stage
`default_nettype none

module cvo_vec #(
   parameter int STAGES = 16,
   parameter int SB_W   = 1
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           en,
   input  wire logic                           in_valid,
   input  wire logic signed [cvo_pkg::VEC_W-1:0] in_x,
   input  wire logic signed [cvo_pkg::VEC_W-1:0] in_y,
   input  wire logic [SB_W-1:0]                in_sb,
   output logic                                out_valid,
   output logic [cvo_pkg::ANG_W-1:0]           out_z,
   output logic [SB_W-1:0]                     out_sb
);

   logic                               v_ff  [STAGES];
   logic signed [cvo_pkg::VEC_W-1:0]   x_ff  [STAGES];
   logic signed [cvo_pkg::VEC_W-1:0]   y_ff  [STAGES];
   logic [cvo_pkg::ANG_W-1:0]          z_ff  [STAGES];
   logic [SB_W-1:0]                    sb_ff [STAGES];

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic                             src_v;
      logic signed [cvo_pkg::VEC_W-1:0] src_x, src_y, xs, ys, x_in, y_in;
      logic [cvo_pkg::ANG_W-1:0]        src_z, z_in;
      logic [SB_W-1:0]                  src_sb;

      if (i == 0) begin : g_first
         assign src_v  = in_valid;
         assign src_x  = in_x;
         assign src_y  = in_y;
         assign src_z  = '0;
         assign src_sb = in_sb;
      end else begin : g_next
         assign src_v  = v_ff[i-1];
         assign src_x  = x_ff[i-1];
         assign src_y  = y_ff[i-1];
         assign src_z  = z_ff[i-1];
         assign src_sb = sb_ff[i-1];
      end

      always_comb begin
         xs = src_x >>> i;
         ys = src_y >>> i;
         if (src_y > 0) begin
            x_in = src_x + ys;
            y_in = src_y - xs;
            z_in = src_z + cvo_pkg::ATAN_TABLE[i];
         end else begin
            x_in = src_x - ys;
            y_in = src_y + xs;
            z_in = src_z - cvo_pkg::ATAN_TABLE[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i]  <= x_in;
            y_ff[i]  <= y_in;
            z_ff[i]  <= z_in;
            sb_ff[i] <= src_sb;
         end
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_z     = z_ff[STAGES-1];
   assign out_sb    = sb_ff[STAGES-1];

endmodule

`default_nettype wire

@@ hdl/cvo_rot.sv @@
// pipelined rotation cordic: cos and sin of a binary angle, rounded to q1.14
`default_nettype none

module cvo_rot #(
   parameter int STAGES = 16,
   parameter int SB_W   = 1
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        en,
   input  wire logic                        in_valid,
   input  wire logic [cvo_pkg::ANG_W-1:0]   in_angle,
   input  wire logic [SB_W-1:0]             in_sb,
   output logic                             out_valid,
   output logic signed [15:0]               out_x,
   output logic signed [15:0]               out_y,
   output logic [SB_W-1:0]                  out_sb
);

   localparam int W = cvo_pkg::ROT_W;

   function automatic logic signed [15:0] to_q14(input logic signed [W-1:0] v);
      logic signed [W-1:0]  sum;
      logic signed [W-17:0] r;
      sum = v + W'(32768);
      r   = (W-16)'(sum >>> 16);
      if (r > (W-16)'(16384)) begin
         return 16'sd16384;
      end else if (r < -(W-16)'(16384)) begin
         return -16'sd16384;
      end
      return r[15:0];
   endfunction

   // fold stage
   logic                      f_v_ff;
   logic signed [31:0]        f_z_ff;
   logic                      f_flip_ff;
   logic [SB_W-1:0]           f_sb_ff;
   logic signed [31:0]        f_z_in;
   logic                      f_flip_in;

   always_comb begin
      if ($signed(in_angle) > 32'sh4000_0000 || $signed(in_angle) < -32'sh4000_0000) begin
         f_z_in    = $signed(in_angle + 32'h8000_0000);
         f_flip_in = 1'b1;
      end else begin
         f_z_in    = $signed(in_angle);
         f_flip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
      end else if (en) begin
         f_v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_z_ff    <= f_z_in;
         f_flip_ff <= f_flip_in;
         f_sb_ff   <= in_sb;
      end
   end

   logic                v_ff    [STAGES];
   logic signed [W-1:0] x_ff    [STAGES];
   logic signed [W-1:0] y_ff    [STAGES];
   logic signed [31:0]  z_ff    [STAGES];
   logic                flip_ff [STAGES];
   logic [SB_W-1:0]     sb_ff   [STAGES];

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic                src_v, src_flip;
      logic signed [W-1:0] src_x, src_y, xs, ys, x_in, y_in;
      logic signed [31:0]  src_z, z_in;
      logic [SB_W-1:0]     src_sb;

      if (i == 0) begin : g_first
         assign src_v    = f_v_ff;
         assign src_x    = $signed(cvo_pkg::CORDIC_GAIN_Q30);
         assign src_y    = '0;
         assign src_z    = f_z_ff;
         assign src_flip = f_flip_ff;
         assign src_sb   = f_sb_ff;
      end else begin : g_next
         assign src_v    = v_ff[i-1];
         assign src_x    = x_ff[i-1];
         assign src_y    = y_ff[i-1];
         assign src_z    = z_ff[i-1];
         assign src_flip = flip_ff[i-1];
         assign src_sb   = sb_ff[i-1];
      end

      always_comb begin
         xs = src_x >>> i;
         ys = src_y >>> i;
         if (!src_z[31]) begin
            x_in = src_x - ys;
            y_in = src_y + xs;
            z_in = src_z - $signed(cvo_pkg::ATAN_TABLE[i]);
         end else begin
            x_in = src_x + ys;
            y_in = src_y - xs;
            z_in = src_z + $signed(cvo_pkg::ATAN_TABLE[i]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i]    <= x_in;
            y_ff[i]    <= y_in;
            z_ff[i]    <= z_in;
            flip_ff[i] <= src_flip;
            sb_ff[i]   <= src_sb;
         end
      end
   end

   // output stage: undo the fold, round and saturate
   logic                o_v_ff;
   logic signed [15:0]  o_x_ff, o_y_ff, o_x_in, o_y_in;
   logic [SB_W-1:0]     o_sb_ff;

   always_comb begin
      if (flip_ff[STAGES-1]) begin
         o_x_in = to_q14(-x_ff[STAGES-1]);
         o_y_in = to_q14(-y_ff[STAGES-1]);
      end else begin
         o_x_in = to_q14(x_ff[STAGES-1]);
         o_y_in = to_q14(y_ff[STAGES-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
      end else if (en) begin
         o_v_ff <= v_ff[STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         o_x_ff  <= o_x_in;
         o_y_ff  <= o_y_in;
         o_sb_ff <= sb_ff[STAGES-1];
      end
   end

   assign out_valid = o_v_ff;
   assign out_x     = o_x_ff;
   assign out_y     = o_y_ff;
   assign out_sb    = o_sb_ff;

endmodule

`default_nettype wire

@@ hdl/circle_velocity_obstacle.sv @@
// circle velocity obstacle: top level of the cone pipeline
//
// req channel: one word per obstacle/robot pair (centres, radii, obstacle
// velocity). rsp channel: one word per request, in order: cone apex (the
// obstacle velocity), two unit side vectors in q1.14 and the overlap flag.
// both channels hand over a word on a clock edge with valid high and stall
// low.
// the datapath is one pipeline: differences and squares, a vectoring cordic
// for the bearing, a 21-step square root, a vectoring cordic for the opening
// angle and two rotation cordics for the side vectors.
// throughput is one word per cycle while rsp is not stalled; the pipeline
// keeps taking words while results flow out.
// a stall on rsp while rsp_valid is high freezes every stage, including the
// output register, and req_stall rises in the same cycle; nothing is dropped
// or repeated. synchronous reset clears all stage valid bits; the pipeline
// is empty and ready on the first cycle after reset.
`default_nettype none

module circle_velocity_obstacle #(
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [19:0] req_obstacle_x,
   input  wire logic signed [19:0] req_obstacle_y,
   input  wire logic [15:0]        req_obstacle_radius,
   input  wire logic signed [19:0] req_robot_x,
   input  wire logic signed [19:0] req_robot_y,
   input  wire logic [15:0]        req_robot_radius,
   input  wire logic signed [19:0] req_obstacle_vel_x,
   input  wire logic signed [19:0] req_obstacle_vel_y,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [19:0]      rsp_apex_x,
   output logic signed [19:0]      rsp_apex_y,
   output logic signed [15:0]      rsp_side_one_x,
   output logic signed [15:0]      rsp_side_one_y,
   output logic signed [15:0]      rsp_side_two_x,
   output logic signed [15:0]      rsp_side_two_y,
   output logic                    rsp_overlapping
);

   localparam int VW = cvo_pkg::VEC_W;
   localparam int SN = cvo_pkg::SQRT_STEPS;

   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // stage a: centre differences and radius sum
   logic               a_v_ff;
   logic signed [20:0] a_dx_ff, a_dy_ff, a_dx_in, a_dy_in;
   logic [16:0]        a_sum_ff, a_sum_in;
   logic [19:0]        a_vx_ff, a_vy_ff;

   assign a_dx_in  = {req_obstacle_x[19], req_obstacle_x} - {req_robot_x[19], req_robot_x};
   assign a_dy_in  = {req_obstacle_y[19], req_obstacle_y} - {req_robot_y[19], req_robot_y};
   assign a_sum_in = {1'b0, req_obstacle_radius} + {1'b0, req_robot_radius};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_dx_ff  <= a_dx_in;
         a_dy_ff  <= a_dy_in;
         a_sum_ff <= a_sum_in;
         a_vx_ff  <= req_obstacle_vel_x;
         a_vy_ff  <= req_obstacle_vel_y;
      end
   end

   // stage b: squares and half-turn fold of the bearing vector
   logic               b_v_ff;
   logic signed [41:0] b_dxsq, b_dysq;
   logic [40:0]        b_dx2_ff, b_dy2_ff;
   logic [33:0]        b_s2_ff, b_s2_in;
   logic               b_zero_ff, b_neg_ff, b_zero_in, b_neg_in;
   logic [19:0]        b_ax_ff;
   logic signed [20:0] b_ay_ff, b_ax_in, b_ay_in;
   logic [16:0]        b_sum_ff;
   logic [19:0]        b_vx_ff, b_vy_ff;

   assign b_dxsq    = a_dx_ff * a_dx_ff;
   assign b_dysq    = a_dy_ff * a_dy_ff;
   assign b_s2_in   = a_sum_ff * a_sum_ff;
   assign b_zero_in = (a_dx_ff == '0) && (a_dy_ff == '0);
   assign b_neg_in  = a_dx_ff[20];
   assign b_ax_in   = b_neg_in ? -a_dx_ff : a_dx_ff;
   assign b_ay_in   = b_neg_in ? -a_dy_ff : a_dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (en) begin
         b_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_dx2_ff  <= b_dxsq[40:0];
         b_dy2_ff  <= b_dysq[40:0];
         b_s2_ff   <= b_s2_in;
         b_zero_ff <= b_zero_in;
         b_neg_ff  <= b_neg_in;
         b_ax_ff   <= b_ax_in[19:0];
         b_ay_ff   <= b_ay_in;
         b_sum_ff  <= a_sum_ff;
         b_vx_ff   <= a_vx_ff;
         b_vy_ff   <= a_vy_ff;
      end
   end

   // stage c: squared distance, overlap test, radicand
   logic               c_v_ff;
   logic [41:0]        c_d2;
   logic               c_overlap_in;
   logic [40:0]        c_n_in;
   logic [19:0]        c_ax_ff;
   logic signed [20:0] c_ay_ff;
   cvo_pkg::brg_sb_type c_sb_ff, c_sb_in;

   assign c_d2         = {1'b0, b_dx2_ff} + {1'b0, b_dy2_ff};
   assign c_overlap_in = c_d2 <= {8'b0, b_s2_ff};
   assign c_n_in       = c_d2[40:0] - {7'b0, b_s2_ff};

   always_comb begin
      c_sb_in.n       = c_n_in;
      c_sb_in.sum     = b_sum_ff;
      c_sb_in.overlap = c_overlap_in;
      c_sb_in.zero    = b_zero_ff;
      c_sb_in.neg     = b_neg_ff;
      c_sb_in.vel_x   = b_vx_ff;
      c_sb_in.vel_y   = b_vy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (en) begin
         c_v_ff <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_ax_ff <= b_ax_ff;
         c_ay_ff <= b_ay_ff;
         c_sb_ff <= c_sb_in;
      end
   end

   // bearing
   logic signed [VW-1:0] brg_x, brg_y;
   logic                 brg_v;
   logic [31:0]          brg_z;
   logic [$bits(cvo_pkg::brg_sb_type)-1:0] brg_sb_raw;
   cvo_pkg::brg_sb_type  brg_sb;

   assign brg_x  = {4'b0, c_ax_ff, 20'b0};
   assign brg_y  = {{3{c_ay_ff[20]}}, c_ay_ff, 20'b0};
   assign brg_sb = brg_sb_raw;

   cvo_vec #(
      .STAGES (CORDIC_STAGES),
      .SB_W   ($bits(cvo_pkg::brg_sb_type))
   ) u_vec_brg (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (c_v_ff),
      .in_x      (brg_x),
      .in_y      (brg_y),
      .in_sb     (c_sb_ff),
      .out_valid (brg_v),
      .out_z     (brg_z),
      .out_sb    (brg_sb_raw)
   );

   // square root, one result bit per stage
   logic                  sq_v_ff    [SN+1];
   logic [40:0]           sq_n_ff    [SN+1];
   logic [41:0]           sq_root_ff [SN+1];
   cvo_pkg::sq_sb_type    sq_sb_ff   [SN+1];
   cvo_pkg::sq_sb_type    sq0_sb_in;

   always_comb begin
      sq0_sb_in.bearing = brg_sb.zero ? '0 : brg_z + {brg_sb.neg, 31'b0};
      sq0_sb_in.sum     = brg_sb.sum;
      sq0_sb_in.overlap = brg_sb.overlap;
      sq0_sb_in.vel_x   = brg_sb.vel_x;
      sq0_sb_in.vel_y   = brg_sb.vel_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else if (en) begin
         sq_v_ff[0] <= brg_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_n_ff[0]    <= brg_sb.n;
         sq_root_ff[0] <= '0;
         sq_sb_ff[0]   <= sq0_sb_in;
      end
   end

   for (genvar k = 0; k < SN; k++) begin : g_sqrt
      localparam logic [41:0] Bit = 42'(1) << (2 * (SN - 1 - k));
      logic [41:0] t;
      logic        take;
      logic [40:0] n_in;
      logic [41:0] root_in;

      assign t       = sq_root_ff[k] + Bit;
      assign take    = {1'b0, sq_n_ff[k]} >= t;
      assign n_in    = take ? sq_n_ff[k] - t[40:0] : sq_n_ff[k];
      assign root_in = take ? (sq_root_ff[k] >> 1) + Bit : sq_root_ff[k] >> 1;

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k+1] <= 1'b0;
         end else if (en) begin
            sq_v_ff[k+1] <= sq_v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sq_n_ff[k+1]    <= n_in;
            sq_root_ff[k+1] <= root_in;
            sq_sb_ff[k+1]   <= sq_sb_ff[k];
         end
      end
   end

   // opening angle: asin(s / d) as atan2(s, sqrt(d^2 - s^2))
   logic signed [VW-1:0] opn_x, opn_y;
   logic                 opn_v;
   logic [31:0]          opn_z;
   cvo_pkg::opn_sb_type  opn_sb_in, opn_sb;
   logic [$bits(cvo_pkg::opn_sb_type)-1:0] opn_sb_raw;

   assign opn_x  = {3'b0, sq_root_ff[SN][20:0], 20'b0};
   assign opn_y  = {7'b0, sq_sb_ff[SN].sum, 20'b0};
   assign opn_sb = opn_sb_raw;

   always_comb begin
      opn_sb_in.bearing = sq_sb_ff[SN].bearing;
      opn_sb_in.overlap = sq_sb_ff[SN].overlap;
      opn_sb_in.vel_x   = sq_sb_ff[SN].vel_x;
      opn_sb_in.vel_y   = sq_sb_ff[SN].vel_y;
   end

   cvo_vec #(
      .STAGES (CORDIC_STAGES),
      .SB_W   ($bits(cvo_pkg::opn_sb_type))
   ) u_vec_opn (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_v_ff[SN]),
      .in_x      (opn_x),
      .in_y      (opn_y),
      .in_sb     (opn_sb_in),
      .out_valid (opn_v),
      .out_z     (opn_z),
      .out_sb    (opn_sb_raw)
   );

   // stage d: side angles
   logic        d_v_ff;
   logic [31:0] d_opening;
   logic [31:0] d_a1_ff, d_a2_ff;
   logic [39:0] d_vel_ff;
   logic        d_overlap_ff;

   assign d_opening = opn_sb.overlap ? cvo_pkg::OVERLAP_OPENING : opn_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= 1'b0;
      end else if (en) begin
         d_v_ff <= opn_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_a1_ff      <= opn_sb.bearing - d_opening;
         d_a2_ff      <= opn_sb.bearing + d_opening;
         d_vel_ff     <= {opn_sb.vel_x, opn_sb.vel_y};
         d_overlap_ff <= opn_sb.overlap;
      end
   end

   logic        r1_v, r2_v;
   logic [39:0] r1_sb;

   cvo_rot #(
      .STAGES (CORDIC_STAGES),
      .SB_W   (40)
   ) u_rot_one (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_v_ff),
      .in_angle  (d_a1_ff),
      .in_sb     (d_vel_ff),
      .out_valid (r1_v),
      .out_x     (rsp_side_one_x),
      .out_y     (rsp_side_one_y),
      .out_sb    (r1_sb)
   );

   cvo_rot #(
      .STAGES (CORDIC_STAGES),
      .SB_W   (1)
   ) u_rot_two (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_v_ff),
      .in_angle  (d_a2_ff),
      .in_sb     (d_overlap_ff),
      .out_valid (r2_v),
      .out_x     (rsp_side_two_x),
      .out_y     (rsp_side_two_y),
      .out_sb    (rsp_overlapping)
   );

   assign rsp_valid  = r1_v & r2_v;
   assign rsp_apex_x = r1_sb[39:20];
   assign rsp_apex_y = r1_sb[19:0];

endmodule

`default_nettype wire

@@ hdl/cvo_checker.sv @@
// port-level checker for the circle velocity obstacle block, with its bind
`default_nettype none
`include "circle_velocity_obstacle_macros.svh"

module cvo_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic signed [19:0] rsp_apex_x,
   input wire logic signed [19:0] rsp_apex_y,
   input wire logic signed [15:0] rsp_side_one_x,
   input wire logic signed [15:0] rsp_side_one_y,
   input wire logic signed [15:0] rsp_side_two_x,
   input wire logic signed [15:0] rsp_side_two_y,
   input wire logic               rsp_overlapping
);

   // a held word keeps its apex, side_one_x, side_two_y and overlap flag
   `CVO_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_apex_x) && $stable(rsp_apex_y) && $stable(rsp_side_one_x) && $stable(rsp_side_two_y) && $stable(rsp_overlapping), "rsp word changed while stalled")

   // req_stall is high exactly when the output is held
   `CVO_ASSERT_NOW(a_stall_link, req_valid || !req_valid, req_stall == (rsp_valid && rsp_stall), "req_stall does not follow output hold")

   // side vectors stay on the saturated unit range
   `CVO_ASSERT_NOW(a_side_range, rsp_valid, rsp_side_one_x <= 16'sd16384 && rsp_side_one_x >= -16'sd16384 && rsp_side_one_y <= 16'sd16384 && rsp_side_one_y >= -16'sd16384 && rsp_side_two_x <= 16'sd16384 && rsp_side_two_x >= -16'sd16384 && rsp_side_two_y <= 16'sd16384 && rsp_side_two_y >= -16'sd16384, "side vector out of range")

   // pipeline comes out of reset empty
   `CVO_ASSERT_NOW(a_reset_empty, $past(reset), !rsp_valid, "rsp_valid set right after reset")

endmodule

bind circle_velocity_obstacle cvo_checker u_cvo_checker (.*);

`default_nettype wire
